/* hw/rtl/rar_pkg.sv */
// Shared widths, field offsets, codes and state types of the rational arithmetic block.
`default_nettype none

package rar_pkg;

   // Operand width; the operand and intermediate widths below follow from it.
   localparam int OPERAND_BITS = 31;
   localparam int NUM_BITS     = OPERAND_BITS;
   localparam int DEN_BITS     = OPERAND_BITS - 1;
   // Widest intermediate magnitude: a sum of two products of operand magnitudes.
   localparam int VAL_BITS     = 2 * OPERAND_BITS - 1;

   // Result field widths are fixed.
   localparam int INT_BITS  = 62;
   localparam int FRAC_BITS = 61;
   localparam int MODE_BITS = 2;

   // Request data layout, lowest field first.
   localparam int A_NUM_LSB      = 0;
   localparam int A_DEN_LSB      = NUM_BITS;
   localparam int B_NUM_LSB      = NUM_BITS + DEN_BITS;
   localparam int B_DEN_LSB      = 2 * NUM_BITS + DEN_BITS;
   localparam int REQ_FIELD_BITS = 2 * (NUM_BITS + DEN_BITS);
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;

   // Response data layout, lowest field first.
   localparam int RSP_NEG_BIT    = 0;
   localparam int RSP_INT_LSB    = 1;
   localparam int RSP_FNUM_LSB   = RSP_INT_LSB + INT_BITS;
   localparam int RSP_FDEN_LSB   = RSP_FNUM_LSB + FRAC_BITS;
   localparam int RSP_FIELD_BITS = RSP_FDEN_LSB + FRAC_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_USER_BITS  = 1;

   // Step counters of the serial units.
   localparam int MUL_CNT_BITS = $clog2(NUM_BITS + 1);
   localparam int DIV_CNT_BITS = $clog2(VAL_BITS + 1);
   localparam int GCD_K_BITS   = $clog2(VAL_BITS);

   typedef logic [VAL_BITS-1:0] val_type;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_ADD,
      MODE_SUB,
      MODE_MUL,
      MODE_DIV
   } mode_type;

   typedef enum logic [1:0] {
      GCD_IDLE,
      GCD_REDUCE,
      GCD_SHIFT
   } gcd_state_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GCD_DEN,
      ST_DIV_A,
      ST_DIV_B,
      ST_MUL_LCM,
      ST_MUL_TA,
      ST_MUL_TB,
      ST_MUL_NUM,
      ST_MUL_DEN,
      ST_DIV_WHOLE,
      ST_GCD_REM,
      ST_DIV_REM,
      ST_DIV_DEN,
      ST_OUT
   } top_state_type;

endpackage

`default_nettype wire

/* hw/rtl/rational_arithmetic_reduce.sv */
// Top level: fraction arithmetic with reduction to a mixed number in lowest terms.
//
//   Channel | Direction | Signals                      | Contents
//   req     | in        | tvalid tready tdata tuser    | two fractions, mode in tuser
//   rsp     | out       | tvalid tready tdata tuser    | mixed number, infinite flag in tuser
//
// One request at a time. Multiply and divide run two multiplies, a divide, a gcd pass
// and two more divides on the bit-serial multiplier, divider and gcd unit; add and
// subtract run a gcd pass, two divides, three multiplies, a divide, a gcd pass and two
// more divides. A request with an infinite result goes straight to the output step.
// Reset is synchronous and clears the sequencer and the response valid flag.
// A finished response waits in its output register; a new request is taken meanwhile
// and its result holds in the last step until the response register is free.
`default_nettype none

module rational_arithmetic_reduce (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // a_numerator, a_denominator, b_numerator, b_denominator, zero pad
   input  wire logic [rar_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // mode
   input  wire logic [rar_pkg::MODE_BITS-1:0]      req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // negative, integer_part, frac_numerator, frac_denominator, zero pad
   output logic [rar_pkg::RSP_DATA_BITS-1:0]       rsp_tdata,
   // infinite
   output logic [rar_pkg::RSP_USER_BITS-1:0]       rsp_tuser
);
   import rar_pkg::*;

   // Sequencer and operand registers.
   top_state_type             state_ff, state_in;
   logic                      issue_ff, issue_in;
   mode_type                  mode_ff, mode_in;
   logic [NUM_BITS-1:0]       an_ff, an_in;
   logic                      an_neg_ff, an_neg_in;
   logic [DEN_BITS-1:0]       ad_ff, ad_in;
   logic [NUM_BITS-1:0]       bn_ff, bn_in;
   logic                      bn_neg_ff, bn_neg_in;
   logic [DEN_BITS-1:0]       bd_ff, bd_in;
   logic                      inf_ff, inf_in;
   logic                      neg_ff, neg_in;
   val_type                   g_ff, g_in;
   val_type                   t0_ff, t0_in;
   val_type                   t1_ff, t1_in;
   val_type                   num_ff, num_in;
   val_type                   den_ff, den_in;
   val_type                   whole_ff, whole_in;
   val_type                   rem_ff, rem_in;
   logic                      rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata_ff, rsp_tdata_in;
   logic [RSP_USER_BITS-1:0]  rsp_tuser_ff, rsp_tuser_in;

   // Request decode.
   logic                      req_accept;
   mode_type                  req_mode;
   logic [NUM_BITS-1:0]       req_an_raw;
   logic [NUM_BITS-1:0]       req_bn_raw;
   logic [NUM_BITS-1:0]       req_an_mag;
   logic [NUM_BITS-1:0]       req_bn_mag;
   logic [DEN_BITS-1:0]       req_ad;
   logic [DEN_BITS-1:0]       req_bd;
   logic                      req_inf;

   // Serial unit connections.
   logic                      mul_start, mul_done;
   val_type                   mul_x;
   logic [NUM_BITS-1:0]       mul_y;
   val_type                   mul_product;
   logic                      div_start, div_done;
   val_type                   div_n, div_d;
   val_type                   div_quot, div_rem;
   logic                      gcd_start, gcd_done;
   val_type                   gcd_x, gcd_y;
   val_type                   gcd_result;

   // Sum of the scaled numerators and response staging.
   logic                      tb_neg;
   logic                      rsp_free;
   logic                      res_negative;

   // Split the request into signs and magnitudes.
   assign req_accept = req_tvalid && req_tready;
   assign req_mode   = mode_type'(req_tuser);
   assign req_an_raw = req_tdata[A_NUM_LSB +: NUM_BITS];
   assign req_bn_raw = req_tdata[B_NUM_LSB +: NUM_BITS];
   assign req_ad     = req_tdata[A_DEN_LSB +: DEN_BITS];
   assign req_bd     = req_tdata[B_DEN_LSB +: DEN_BITS];
   assign req_an_mag = req_an_raw[NUM_BITS-1] ? (~req_an_raw + 1'b1) : req_an_raw;
   assign req_bn_mag = req_bn_raw[NUM_BITS-1] ? (~req_bn_raw + 1'b1) : req_bn_raw;
   assign req_inf    = (req_ad == '0) || (req_bd == '0) ||
                       ((req_mode == MODE_DIV) && (req_bn_raw == '0));

   assign req_tready   = (state_ff == ST_IDLE);
   assign rsp_free     = !rsp_tvalid_ff || rsp_tready;
   assign tb_neg       = (mode_ff == MODE_SUB) ? !bn_neg_ff : bn_neg_ff;
   assign res_negative = neg_ff && (num_ff != '0);

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               priority if (req_inf) begin
                  state_in = ST_OUT;
               end else if ((req_mode == MODE_ADD) || (req_mode == MODE_SUB)) begin
                  state_in = ST_GCD_DEN;
               end else begin
                  state_in = ST_MUL_NUM;
               end
            end
         end
         ST_GCD_DEN:   if (gcd_done) state_in = ST_DIV_A;
         ST_DIV_A:     if (div_done) state_in = ST_DIV_B;
         ST_DIV_B:     if (div_done) state_in = ST_MUL_LCM;
         ST_MUL_LCM:   if (mul_done) state_in = ST_MUL_TA;
         ST_MUL_TA:    if (mul_done) state_in = ST_MUL_TB;
         ST_MUL_TB:    if (mul_done) state_in = ST_DIV_WHOLE;
         ST_MUL_NUM:   if (mul_done) state_in = ST_MUL_DEN;
         ST_MUL_DEN:   if (mul_done) state_in = ST_DIV_WHOLE;
         ST_DIV_WHOLE: if (div_done) state_in = ST_GCD_REM;
         ST_GCD_REM:   if (gcd_done) state_in = ST_DIV_REM;
         ST_DIV_REM:   if (div_done) state_in = ST_DIV_DEN;
         ST_DIV_DEN:   if (div_done) state_in = ST_OUT;
         ST_OUT:       if (rsp_free) state_in = ST_IDLE;
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Unit starts and operand selection for each step.
   always_comb begin
      mul_start = 1'b0;
      div_start = 1'b0;
      gcd_start = 1'b0;
      mul_x     = '0;
      mul_y     = '0;
      div_n     = '0;
      div_d     = '0;
      gcd_x     = '0;
      gcd_y     = '0;
      unique case (state_ff)
         ST_GCD_DEN: begin
            gcd_start = issue_ff;
            gcd_x     = VAL_BITS'(ad_ff);
            gcd_y     = VAL_BITS'(bd_ff);
         end
         ST_DIV_A: begin
            div_start = issue_ff;
            div_n     = VAL_BITS'(ad_ff);
            div_d     = g_ff;
         end
         ST_DIV_B: begin
            div_start = issue_ff;
            div_n     = VAL_BITS'(bd_ff);
            div_d     = g_ff;
         end
         ST_MUL_LCM: begin
            mul_start = issue_ff;
            mul_x     = t0_ff;
            mul_y     = NUM_BITS'(bd_ff);
         end
         ST_MUL_TA: begin
            mul_start = issue_ff;
            mul_x     = VAL_BITS'(an_ff);
            mul_y     = NUM_BITS'(t1_ff);
         end
         ST_MUL_TB: begin
            mul_start = issue_ff;
            mul_x     = VAL_BITS'(bn_ff);
            mul_y     = NUM_BITS'(t0_ff);
         end
         ST_MUL_NUM: begin
            mul_start = issue_ff;
            mul_x     = VAL_BITS'(an_ff);
            mul_y     = (mode_ff == MODE_DIV) ? NUM_BITS'(bd_ff) : bn_ff;
         end
         ST_MUL_DEN: begin
            mul_start = issue_ff;
            mul_x     = VAL_BITS'(ad_ff);
            mul_y     = (mode_ff == MODE_DIV) ? bn_ff : NUM_BITS'(bd_ff);
         end
         ST_DIV_WHOLE: begin
            div_start = issue_ff;
            div_n     = num_ff;
            div_d     = den_ff;
         end
         ST_GCD_REM: begin
            gcd_start = issue_ff;
            gcd_x     = den_ff;
            gcd_y     = rem_ff;
         end
         ST_DIV_REM: begin
            div_start = issue_ff;
            div_n     = rem_ff;
            div_d     = g_ff;
         end
         ST_DIV_DEN: begin
            div_start = issue_ff;
            div_n     = den_ff;
            div_d     = g_ff;
         end
         default: begin
            mul_start = 1'b0;
         end
      endcase
   end

   // Working registers load the request, then take each unit's result as it finishes.
   always_comb begin
      issue_in      = (state_in != state_ff);
      mode_in       = mode_ff;
      an_in         = an_ff;
      an_neg_in     = an_neg_ff;
      ad_in         = ad_ff;
      bn_in         = bn_ff;
      bn_neg_in     = bn_neg_ff;
      bd_in         = bd_ff;
      inf_in        = inf_ff;
      neg_in        = neg_ff;
      g_in          = g_ff;
      t0_in         = t0_ff;
      t1_in         = t1_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      whole_in      = whole_ff;
      rem_in        = rem_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               mode_in   = req_mode;
               an_in     = req_an_mag;
               an_neg_in = req_an_raw[NUM_BITS-1];
               ad_in     = req_ad;
               bn_in     = req_bn_mag;
               bn_neg_in = req_bn_raw[NUM_BITS-1];
               bd_in     = req_bd;
               inf_in    = req_inf;
               neg_in    = req_an_raw[NUM_BITS-1] ^ req_bn_raw[NUM_BITS-1];
            end
         end
         ST_GCD_DEN: if (gcd_done) g_in   = gcd_result;
         ST_DIV_A:   if (div_done) t0_in  = div_quot;
         ST_DIV_B:   if (div_done) t1_in  = div_quot;
         ST_MUL_LCM: if (mul_done) den_in = mul_product;
         ST_MUL_TA:  if (mul_done) num_in = mul_product;
         ST_MUL_TB: begin
            // Signed sum of the two scaled numerators, kept as sign and magnitude.
            if (mul_done) begin
               priority if (an_neg_ff == tb_neg) begin
                  num_in = num_ff + mul_product;
                  neg_in = an_neg_ff;
               end else if (num_ff >= mul_product) begin
                  num_in = num_ff - mul_product;
                  neg_in = an_neg_ff;
               end else begin
                  num_in = mul_product - num_ff;
                  neg_in = tb_neg;
               end
            end
         end
         ST_MUL_NUM: if (mul_done) num_in = mul_product;
         ST_MUL_DEN: if (mul_done) den_in = mul_product;
         ST_DIV_WHOLE: begin
            if (div_done) begin
               whole_in = div_quot;
               rem_in   = div_rem;
            end
         end
         ST_GCD_REM: if (gcd_done) g_in   = gcd_result;
         ST_DIV_REM: if (div_done) rem_in = div_quot;
         ST_DIV_DEN: if (div_done) den_in = div_quot;
         ST_OUT: begin
            // Load the response register once it is free.
            if (rsp_free) begin
               rsp_tvalid_in = 1'b1;
               if (inf_ff) begin
                  rsp_tuser_in = RSP_USER_BITS'(1);
                  rsp_tdata_in = RSP_DATA_BITS'({FRAC_BITS'(1), FRAC_BITS'(0),
                                                 INT_BITS'(0), 1'b0});
               end else begin
                  rsp_tuser_in = RSP_USER_BITS'(0);
                  rsp_tdata_in = RSP_DATA_BITS'({FRAC_BITS'(den_ff), FRAC_BITS'(rem_ff),
                                                 INT_BITS'(whole_ff), res_negative});
               end
            end
         end
         default: begin
            issue_in = 1'b0;
         end
      endcase
   end

   // Control state is reset; payload registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         issue_ff      <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         issue_ff      <= issue_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      mode_ff      <= mode_in;
      an_ff        <= an_in;
      an_neg_ff    <= an_neg_in;
      ad_ff        <= ad_in;
      bn_ff        <= bn_in;
      bn_neg_ff    <= bn_neg_in;
      bd_ff        <= bd_in;
      inf_ff       <= inf_in;
      neg_ff       <= neg_in;
      g_ff         <= g_in;
      t0_ff        <= t0_in;
      t1_ff        <= t1_in;
      num_ff       <= num_in;
      den_ff       <= den_in;
      whole_ff     <= whole_in;
      rem_ff       <= rem_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // Shared serial units.
   rar_serial_mul u_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start),
      .multiplicand (mul_x),
      .multiplier   (mul_y),
      .done         (mul_done),
      .product      (mul_product)
   );

   rar_serial_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_n),
      .divisor   (div_d),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   rar_binary_gcd u_gcd (
      .clock  (clock),
      .reset  (reset),
      .start  (gcd_start),
      .x      (gcd_x),
      .y      (gcd_y),
      .done   (gcd_done),
      .result (gcd_result)
   );

   // A reduced finite result has a proper fraction part.
   a_proper_fraction: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |->
         rsp_tdata[RSP_FNUM_LSB +: FRAC_BITS] < rsp_tdata[RSP_FDEN_LSB +: FRAC_BITS])
      else $error("fraction numerator not below denominator");

   // A negative result is never zero.
   a_negative_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_NEG_BIT] |->
         (rsp_tdata[RSP_INT_LSB +: INT_BITS] != '0) ||
         (rsp_tdata[RSP_FNUM_LSB +: FRAC_BITS] != '0))
      else $error("negative flag on a zero result");

   // An infinite result carries the fixed field values.
   a_infinite_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         rsp_tdata == RSP_DATA_BITS'({FRAC_BITS'(1), FRAC_BITS'(0), INT_BITS'(0), 1'b0}))
      else $error("infinite result with unexpected fields");

   // The serial units never finish in the same cycle.
   a_one_unit_done: assert property (@(posedge clock) disable iff (reset)
      $onehot0({mul_done, div_done, gcd_done}))
      else $error("two serial units finished together");

   // A multiplier result only arrives in a multiply step.
   a_mul_done_state: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_MUL_LCM) || (state_ff == ST_MUL_TA) ||
                   (state_ff == ST_MUL_TB) || (state_ff == ST_MUL_NUM) ||
                   (state_ff == ST_MUL_DEN))
      else $error("multiplier finished outside a multiply step");

endmodule

`default_nettype wire

/* hw/rtl/rar_serial_mul.sv */
// Shift-and-add multiplier that takes one multiplier bit per cycle.
`default_nettype none

module rar_serial_mul (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire rar_pkg::val_type              multiplicand,
   input  wire logic [rar_pkg::NUM_BITS-1:0]  multiplier,
   output logic                               done,
   output rar_pkg::val_type                   product
);
   import rar_pkg::*;

   val_type                 acc_ff, acc_in;
   val_type                 mcand_ff, mcand_in;
   logic [NUM_BITS-1:0]     mplier_ff, mplier_in;
   logic [MUL_CNT_BITS-1:0] count_ff, count_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;

   // One step: add the shifted multiplicand when the low multiplier bit is set.
   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      count_in  = count_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         acc_in    = '0;
         mcand_in  = multiplicand;
         mplier_in = multiplier;
         count_in  = MUL_CNT_BITS'(NUM_BITS);
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = {mcand_ff[VAL_BITS-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[NUM_BITS-1:1]};
         count_in  = count_ff - 1'b1;
         if (count_ff == MUL_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state is reset; the data path is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      count_ff  <= count_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

/* hw/rtl/rar_serial_div.sv */
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module rar_serial_div (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire rar_pkg::val_type dividend,
   input  wire rar_pkg::val_type divisor,
   output logic                  done,
   output rar_pkg::val_type      quotient,
   output rar_pkg::val_type      remainder
);
   import rar_pkg::*;

   val_type                 quot_ff, quot_in;
   val_type                 rem_ff, rem_in;
   val_type                 div_ff, div_in;
   logic [DIV_CNT_BITS-1:0] count_ff, count_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [VAL_BITS:0]       trial;
   logic [VAL_BITS:0]       diff;
   logic                    fits;

   // The next dividend bit moves into the partial remainder.
   assign trial = {rem_ff, quot_ff[VAL_BITS-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign fits  = (trial >= {1'b0, div_ff});

   // One step: subtract the divisor when it fits and record the quotient bit.
   always_comb begin
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         quot_in  = dividend;
         rem_in   = '0;
         div_in   = divisor;
         count_in = DIV_CNT_BITS'(VAL_BITS);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[VAL_BITS-1:0] : trial[VAL_BITS-1:0];
         quot_in  = {quot_ff[VAL_BITS-2:0], fits};
         count_in = count_ff - 1'b1;
         if (count_ff == DIV_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state is reset; the data path is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      count_ff <= count_in;
   end

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

/* hw/rtl/rar_binary_gcd.sv */
// Binary greatest common divisor: one subtract or halving step per cycle.
`default_nettype none

module rar_binary_gcd (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire rar_pkg::val_type x,
   input  wire rar_pkg::val_type y,
   output logic                  done,
   output rar_pkg::val_type      result
);
   import rar_pkg::*;

   gcd_state_type         state_ff, state_in;
   val_type               x_ff, x_in;
   val_type               y_ff, y_in;
   logic [GCD_K_BITS-1:0] k_ff, k_in;
   logic                  done_ff, done_in;
   logic                  x_zero;
   logic                  y_zero;
   logic                  x_ge_y;
   val_type               x_minus_y;
   val_type               y_minus_x;

   assign x_zero    = (x_ff == '0);
   assign y_zero    = (y_ff == '0);
   assign x_ge_y    = (x_ff >= y_ff);
   assign x_minus_y = x_ff - y_ff;
   assign y_minus_x = y_ff - x_ff;

   // Next state: reduce until one operand is zero, then restore common twos.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         GCD_IDLE: begin
            if (start) begin
               state_in = GCD_REDUCE;
            end
         end
         GCD_REDUCE: begin
            if (x_zero || y_zero) begin
               state_in = GCD_SHIFT;
            end
         end
         GCD_SHIFT: begin
            if (k_ff == '0) begin
               state_in = GCD_IDLE;
            end
         end
         default: begin
            state_in = GCD_IDLE;
         end
      endcase
   end

   // Operand updates and the done pulse.
   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      k_in    = k_ff;
      done_in = 1'b0;
      unique case (state_ff)
         GCD_IDLE: begin
            if (start) begin
               x_in = x;
               y_in = y;
               k_in = '0;
            end
         end
         GCD_REDUCE: begin
            priority if (x_zero || y_zero) begin
               x_in = x_ff | y_ff;
            end else if (!x_ff[0] && !y_ff[0]) begin
               x_in = {1'b0, x_ff[VAL_BITS-1:1]};
               y_in = {1'b0, y_ff[VAL_BITS-1:1]};
               k_in = k_ff + 1'b1;
            end else if (!x_ff[0]) begin
               x_in = {1'b0, x_ff[VAL_BITS-1:1]};
            end else if (!y_ff[0]) begin
               y_in = {1'b0, y_ff[VAL_BITS-1:1]};
            end else if (x_ge_y) begin
               x_in = {1'b0, x_minus_y[VAL_BITS-1:1]};
            end else begin
               y_in = {1'b0, y_minus_x[VAL_BITS-1:1]};
            end
         end
         GCD_SHIFT: begin
            if (k_ff == '0) begin
               done_in = 1'b1;
            end else begin
               x_in = {x_ff[VAL_BITS-2:0], 1'b0};
               k_in = k_ff - 1'b1;
            end
         end
         default: begin
            done_in = 1'b0;
         end
      endcase
   end

   // Control state is reset; the operands are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= GCD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      k_ff <= k_in;
   end

   assign done   = done_ff;
   assign result = x_ff;

endmodule

`default_nettype wire

/* tb/rational_arithmetic_reduce_checker.sv */
// Checker for the rational arithmetic block: predicts each response from its request and compares.
`timescale 1ns / 1ps

module rational_arithmetic_reduce_checker
   import rar_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   input  wire logic                     req_tready,
   // a_numerator, a_denominator, b_numerator, b_denominator, zero pad
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   // mode
   input  wire logic [MODE_BITS-1:0]     req_tuser,
   input  wire logic                     rsp_tvalid,
   input  wire logic                     rsp_tready,
   // negative, integer_part, frac_numerator, frac_denominator, zero pad
   input  wire logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // infinite
   input  wire logic [RSP_USER_BITS-1:0] rsp_tuser,
   output int                            fail_count,
   output int                            open_count
);

   typedef struct packed {
      logic                 infinite;
      logic                 negative;
      logic [INT_BITS-1:0]  whole;
      logic [FRAC_BITS-1:0] fnum;
      logic [FRAC_BITS-1:0] fden;
   } mixed_number_type;

   mixed_number_type mixed_due[$];
   int               errors = 0;

   initial begin
      fail_count = 0;
      open_count = 0;
   end

   // Euclid's greatest common divisor on 64-bit magnitudes.
   function automatic logic [63:0] gcd64(input logic [63:0] x, input logic [63:0] y);
      logic [63:0] r;
      while (y != 64'd0) begin
         r = x % y;
         x = y;
         y = r;
      end
      return x;
   endfunction

   // Magnitude of a two's complement numerator; the most negative value keeps its true size.
   function automatic logic [63:0] magnitude(input logic [NUM_BITS-1:0] raw);
      if (raw[NUM_BITS-1])
         return (64'd1 << NUM_BITS) - 64'(raw);
      return 64'(raw);
   endfunction

   // Exact fraction arithmetic, reduced to lowest terms and split into a mixed number.
   function automatic mixed_number_type reduce_fraction_pair(
      input mode_type              m,
      input logic [NUM_BITS-1:0]   an_raw,
      input logic [DEN_BITS-1:0]   ad_raw,
      input logic [NUM_BITS-1:0]   bn_raw,
      input logic [DEN_BITS-1:0]   bd_raw
   );
      mixed_number_type res;
      logic [63:0]      an, ad, bn, bd, lcm, ta, tb, num, den, whole, rem, g;
      logic             an_neg, bn_neg, tb_neg, neg;
      an     = magnitude(an_raw);
      bn     = magnitude(bn_raw);
      an_neg = an_raw[NUM_BITS-1];
      bn_neg = bn_raw[NUM_BITS-1];
      ad     = 64'(ad_raw);
      bd     = 64'(bd_raw);
      res    = '0;
      res.fden = FRAC_BITS'(1);

      // A zero denominator gives no finite value.
      if (ad == 64'd0 || bd == 64'd0) begin
         res.infinite = 1'b1;
         return res;
      end

      case (m)
         MODE_ADD, MODE_SUB: begin
            lcm    = (ad / gcd64(ad, bd)) * bd;
            ta     = an * (lcm / ad);
            tb     = bn * (lcm / bd);
            tb_neg = (m == MODE_SUB) ? !bn_neg : bn_neg;
            if (an_neg == tb_neg) begin
               num = ta + tb;
               neg = an_neg;
            end else if (ta >= tb) begin
               num = ta - tb;
               neg = an_neg;
            end else begin
               num = tb - ta;
               neg = tb_neg;
            end
            den = lcm;
         end
         MODE_MUL: begin
            num = an * bn;
            den = ad * bd;
            neg = an_neg != bn_neg;
         end
         default: begin
            // Division by a zero-valued fraction.
            if (bn == 64'd0) begin
               res.infinite = 1'b1;
               return res;
            end
            num = an * bd;
            den = ad * bn;
            neg = an_neg != bn_neg;
         end
      endcase

      whole = num / den;
      rem   = num % den;
      g     = gcd64(den, rem);
      rem   = rem / g;
      den   = den / g;

      // A zero result is never reported as negative.
      res.negative = neg && (num != 64'd0);
      res.whole    = whole[INT_BITS-1:0];
      res.fnum     = rem[FRAC_BITS-1:0];
      res.fden     = den[FRAC_BITS-1:0];
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("tb: mismatch on %s at %0t: got %0d, expected %0d", what, $realtime, got, want);
      errors++;
   endtask

   // Responses are checked before the request of the same edge is predicted.
   always @(posedge clock) begin : watch
      mixed_number_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (mixed_due.size() == 0) begin
               report_mismatch("response with none outstanding", 64'(rsp_tdata), 64'd0);
            end else begin
               want = mixed_due.pop_front();
               if (rsp_tuser[0] !== want.infinite)
                  report_mismatch("infinite", 64'(rsp_tuser[0]), 64'(want.infinite));
               if (rsp_tdata[RSP_NEG_BIT] !== want.negative)
                  report_mismatch("negative", 64'(rsp_tdata[RSP_NEG_BIT]),
                                  64'(want.negative));
               if (rsp_tdata[RSP_INT_LSB +: INT_BITS] !== want.whole)
                  report_mismatch("integer_part", 64'(rsp_tdata[RSP_INT_LSB +: INT_BITS]),
                                  64'(want.whole));
               if (rsp_tdata[RSP_FNUM_LSB +: FRAC_BITS] !== want.fnum)
                  report_mismatch("frac_numerator",
                                  64'(rsp_tdata[RSP_FNUM_LSB +: FRAC_BITS]), 64'(want.fnum));
               if (rsp_tdata[RSP_FDEN_LSB +: FRAC_BITS] !== want.fden)
                  report_mismatch("frac_denominator",
                                  64'(rsp_tdata[RSP_FDEN_LSB +: FRAC_BITS]), 64'(want.fden));
            end
         end
         if (req_tvalid && req_tready) begin
            mixed_due.push_back(reduce_fraction_pair(
               mode_type'(req_tuser),
               req_tdata[A_NUM_LSB +: NUM_BITS],
               req_tdata[A_DEN_LSB +: DEN_BITS],
               req_tdata[B_NUM_LSB +: NUM_BITS],
               req_tdata[B_DEN_LSB +: DEN_BITS]));
         end
      end
      open_count <= mixed_due.size();
      fail_count <= errors;
   end

endmodule

/* tb/rational_arithmetic_reduce_tb.sv */
// Testbench top for the rational arithmetic block: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module rational_arithmetic_reduce_tb;
   import rar_pkg::*;

   localparam logic [NUM_BITS-1:0] NUM_MAX  = {1'b0, {(NUM_BITS-1){1'b1}}};
   localparam logic [NUM_BITS-1:0] NUM_MIN  = {1'b1, {(NUM_BITS-1){1'b0}}};
   localparam logic [NUM_BITS-1:0] NUM_ZERO = '0;
   localparam logic [DEN_BITS-1:0] DEN_MAX  = '1;
   localparam logic [DEN_BITS-1:0] DEN_ZERO = '0;
   localparam int                  PHASE_ITEMS = 110;
   localparam int                  HOLD_CYCLES = 4000;
   localparam int                  DRAIN_CYCLES = 700;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;
   logic [MODE_BITS-1:0]     req_tuser;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic [RSP_USER_BITS-1:0] rsp_tuser;
   int                       fail_count;
   int                       open_count;

   int   send_idle  = 0;
   int   recv_stall = 0;
   logic start_hold = 1'b0;
   logic hold_rsp   = 1'b0;

   rational_arithmetic_reduce u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   rational_arithmetic_reduce_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .fail_count (fail_count),
      .open_count (open_count)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #30_000_000;
      $display("tb: failure");
      $finish;
   end

   // Receiver: random stalls, and a long hold-off while the pressure phase runs.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_tready <= !hold_rsp && ($urandom_range(99) >= recv_stall);
      end
   end

   // Long receiver hold-off, counted here so the sender keeps offering requests.
   initial begin
      wait (start_hold);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   function automatic logic [NUM_BITS-1:0] to_num(input int v);
      return v[NUM_BITS-1:0];
   endfunction

   // Numerators lean towards zero, the extremes and small values.
   function automatic logic [NUM_BITS-1:0] rand_numerator();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(9))
         0:       return NUM_ZERO;
         1:       return NUM_MIN;
         2:       return NUM_MAX;
         3, 4, 5: return to_num(int'($urandom_range(64)) - 32);
         default: return r[NUM_BITS-1:0];
      endcase
   endfunction

   // Denominators are mostly valid; a zero now and then.
   function automatic logic [DEN_BITS-1:0] rand_denominator();
      logic [31:0] r;
      int          pick;
      pick = $urandom_range(39);
      if (pick == 0)
         return DEN_ZERO;
      if (pick < 4)
         return DEN_MAX;
      if (pick < 20) begin
         r = $urandom_range(60, 1);
         return r[DEN_BITS-1:0];
      end
      r = $urandom;
      return r[DEN_BITS-1:0];
   endfunction

   // Offers one request after a random idle gap and waits until it is accepted.
   task automatic offer(input mode_type m,
                        input logic [NUM_BITS-1:0] an, input logic [DEN_BITS-1:0] ad,
                        input logic [NUM_BITS-1:0] bn, input logic [DEN_BITS-1:0] bd);
      logic [REQ_DATA_BITS-1:0] word;
      word = '0;
      word[A_NUM_LSB +: NUM_BITS] = an;
      word[A_DEN_LSB +: DEN_BITS] = ad;
      word[B_NUM_LSB +: NUM_BITS] = bn;
      word[B_DEN_LSB +: DEN_BITS] = bd;
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tuser  <= m;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic random_requests(input int count);
      repeat (count)
         offer(mode_type'($urandom_range(3)), rand_numerator(), rand_denominator(),
               rand_numerator(), rand_denominator());
   endtask

   // Stimulus and verdict.
   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests: each operation, field extremes and the special cases.
      offer(MODE_ADD, to_num(1), 30'd2, to_num(1), 30'd3);
      offer(MODE_SUB, to_num(1), 30'd2, to_num(1), 30'd2);
      // Negative minus an equal negative: a zero that must not be negative.
      offer(MODE_SUB, to_num(-1), 30'd2, to_num(-1), 30'd2);
      offer(MODE_SUB, to_num(3), 30'd4, to_num(5), 30'd6);
      offer(MODE_ADD, NUM_MAX, 30'd1, NUM_MAX, 30'd1);
      offer(MODE_ADD, NUM_MIN, 30'd1, NUM_MIN, 30'd1);
      offer(MODE_ADD, NUM_MAX, DEN_MAX, NUM_MAX, DEN_MAX - 30'd1);
      offer(MODE_SUB, NUM_MIN, DEN_MAX, NUM_MAX, 30'd1);
      offer(MODE_MUL, NUM_MAX, 30'd1, NUM_MAX, 30'd1);
      offer(MODE_MUL, NUM_MIN, 30'd1, NUM_MIN, 30'd1);
      offer(MODE_MUL, to_num(7), DEN_MAX, to_num(-5), DEN_MAX);
      offer(MODE_MUL, NUM_ZERO, 30'd9, to_num(-4), 30'd3);
      offer(MODE_DIV, to_num(5), 30'd7, NUM_ZERO, 30'd3);
      offer(MODE_DIV, NUM_MIN, 30'd1, to_num(1), DEN_MAX);
      offer(MODE_DIV, NUM_MAX, 30'd1, to_num(1), DEN_MAX);
      offer(MODE_DIV, to_num(-3), 30'd4, to_num(5), 30'd6);
      offer(MODE_DIV, NUM_ZERO, 30'd1, to_num(-5), 30'd1);
      offer(MODE_DIV, NUM_MAX, DEN_MAX, NUM_MIN, DEN_MAX);
      // Zero denominators on either or both operands, then one difference over DEN_MAX.
      offer(MODE_ADD, to_num(2), DEN_ZERO, to_num(3), 30'd5);
      offer(MODE_MUL, to_num(2), 30'd5, to_num(3), DEN_ZERO);
      offer(MODE_DIV, NUM_ZERO, DEN_ZERO, NUM_ZERO, DEN_ZERO);
      offer(MODE_SUB, to_num(-1), 30'd1, to_num(-1), DEN_MAX);

      // Random requests under each idling pattern.
      random_requests(PHASE_ITEMS);
      send_idle  = 85;
      recv_stall = 0;
      random_requests(PHASE_ITEMS);
      send_idle  = 0;
      recv_stall = 85;
      random_requests(PHASE_ITEMS);
      send_idle  = 35;
      recv_stall = 35;
      random_requests(PHASE_ITEMS);

      // Receiver holds off while the sender keeps offering back to back.
      send_idle  = 0;
      recv_stall = 0;
      start_hold = 1'b1;
      random_requests(8);

      // Let the outstanding count take in the last accepted request before waiting on it.
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && open_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
